/* rtl/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope generator.
// Holds the payload structs, phase and register codes, and controller/datapath links.
// No dependencies.
package adsr_pkg;

   localparam int CFG_W              = 24;
   localparam int FRAC_BITS          = 24;
   localparam int LEVEL_W            = FRAC_BITS + 1;
   localparam int CSR_IDX_W          = 2;
   localparam int COUNT_BITS_DEFAULT = 24;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_BITS;

   localparam logic [CFG_W-1:0] ATTACK_RESET  = CFG_W'(2205);
   localparam logic [CFG_W-1:0] SUSTAIN_RESET = CFG_W'(441000);
   localparam logic [CFG_W-1:0] DECAY_RESET   = CFG_W'(13230);
   localparam logic [CFG_W-1:0] RELEASE_RESET = CFG_W'(30870);

   // floor(x/5) = (x * RECIP5) >> RECIP5_SH, exact for x below 2^26
   localparam int               RECIP5_SH = 26;
   localparam logic [CFG_W-1:0] RECIP5    = CFG_W'(13421773);

   // step quotient datapath widths
   localparam int MUL_OP_W  = CFG_W + 1;
   localparam int PROD_W    = 2 * MUL_OP_W;
   localparam int NUM_W     = MUL_OP_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_SUSTAIN = 3'd2,
      PH_DECAY   = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_SUSTAIN = 2'd1,
      CSR_DECAY   = 2'd2,
      CSR_RELEASE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       req_type;
      logic [2:0] new_phase;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      phase_type          phase;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ATK_END,
      OP_ATK_STEP,
      OP_SUS_END,
      OP_SUS_HOLD,
      OP_DEC_HOLD,
      OP_DEC_END,
      OP_DEC_UP,
      OP_DEC_DOWN,
      OP_REL_END,
      OP_REL_STEP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic mul;
      logic div_start;
      logic div_step;
      logic apply;
   } dp_cmd_type;

   typedef struct packed {
      logic req_tick;
      logic need_div;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/adsr_controller.sv */
// Sequencer for the ADSR envelope generator: accept, evaluate, multiply, divide, emit.
// Depends on adsr_pkg.
module adsr_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  adsr_pkg::dp_status_type status,
   output adsr_pkg::dp_cmd_type    cmd
);
   import adsr_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.req_tick) state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.need_div ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/adsr_datapath.sv */
// Datapath of the ADSR envelope generator: registers, envelope state, step
// multiplier, restoring divider and output register. Depends on adsr_pkg.
module adsr_datapath #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  adsr_pkg::dp_cmd_type              cmd,
   output adsr_pkg::dp_status_type           status,
   input  adsr_pkg::req_payload_type         req_data,
   input  logic                              csr_we,
   input  logic [adsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adsr_pkg::CFG_W-1:0]        csr_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output adsr_pkg::rsp_payload_type         rsp_data
);
   import adsr_pkg::*;

   localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [CFG_W-1:0]      attack_len_ff, sustain_len_ff, decay_len_ff, release_len_ff;
   logic [2*CFG_W-1:0]    d5_prod_ff;
   phase_type             cur_phase_ff, cur_phase_in;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in;
   logic [LEVEL_W-1:0]    cur_level_ff, cur_level_in;
   op_type                op_ff, op_in;
   logic [MUL_OP_W-1:0]   mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [PROD_W-1:0]     prod_ff, den_ff, rem_ff, rem_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= ATTACK_RESET;
         sustain_len_ff <= SUSTAIN_RESET;
         decay_len_ff   <= DECAY_RESET;
         release_len_ff <= RELEASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTACK:  attack_len_ff  <= csr_data;
            CSR_SUSTAIN: sustain_len_ff <= csr_data;
            CSR_DECAY:   decay_len_ff   <= csr_data;
            CSR_RELEASE: release_len_ff <= csr_data;
            default:     attack_len_ff  <= attack_len_ff;
         endcase
      end
   end

   // decay end threshold D - D/5, via reciprocal multiply
   always_ff @(posedge clock) begin
      d5_prod_ff <= (2*CFG_W)'(decay_len_ff) * (2*CFG_W)'(RECIP5);
   end

   logic [CFG_W-1:0]    decay_thr;
   logic [CMP_W-1:0]    t_ext;
   logic [MUL_OP_W-1:0] t_op, hyp_len, hyp_a;

   assign decay_thr = decay_len_ff - CFG_W'(d5_prod_ff >> RECIP5_SH);
   assign t_ext     = CMP_W'(elapsed_ff);
   // t stays below the phase length whenever it feeds the multiplier
   assign t_op      = MUL_OP_W'(elapsed_ff);
   assign hyp_len   = (cur_phase_ff == PH_RELEASE) ? MUL_OP_W'(release_len_ff)
                                                   : MUL_OP_W'(attack_len_ff);
   assign hyp_a     = t_op + hyp_len;

   always_comb begin
      op_in    = OP_IDLE;
      mul_a_in = hyp_a;
      mul_b_in = hyp_a - MUL_OP_W'(1);
      num_in   = {hyp_len << 1, {FRAC_BITS{1'b0}}};
      case (cur_phase_ff)
         PH_ATTACK: begin
            if (cur_level_ff >= LEVEL_ONE || t_ext >= CMP_W'(attack_len_ff)) op_in = OP_ATK_END;
            else op_in = OP_ATK_STEP;
         end
         PH_SUSTAIN: begin
            op_in = (t_ext >= CMP_W'(sustain_len_ff)) ? OP_SUS_END : OP_SUS_HOLD;
         end
         PH_DECAY: begin
            mul_a_in = MUL_OP_W'(decay_len_ff);
            mul_b_in = MUL_OP_W'(decay_len_ff);
            if (t_ext >= CMP_W'(decay_thr)) begin
               op_in = (decay_len_ff == '0) ? OP_DEC_HOLD : OP_DEC_END;
            end else if (t_ext == CMP_W'(1)) begin
               op_in  = OP_DEC_UP;
               num_in = NUM_W'(1) << FRAC_BITS;
            end else begin
               op_in  = OP_DEC_DOWN;
               num_in = {t_op - MUL_OP_W'(2), {FRAC_BITS{1'b0}}};
            end
         end
         PH_RELEASE: begin
            if (t_ext >= CMP_W'(release_len_ff) || cur_level_ff == '0) op_in = OP_REL_END;
            else op_in = OP_REL_STEP;
         end
         default: op_in = OP_IDLE;
      endcase
   end

   assign status.need_div = (op_in == OP_ATK_STEP) || (op_in == OP_DEC_UP) ||
                            (op_in == OP_DEC_DOWN) || (op_in == OP_REL_STEP);
   assign status.req_tick = !req_data.req_type;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // restoring divider, one quotient bit a cycle
   logic [PROD_W:0] part_rem;
   logic            part_ge;

   assign part_rem = {rem_ff, quo_ff[NUM_W-1]};
   assign part_ge  = part_rem >= {1'b0, den_ff};
   assign rem_in   = part_ge ? PROD_W'(part_rem - {1'b0, den_ff}) : PROD_W'(part_rem);
   assign quo_in   = {quo_ff[NUM_W-2:0], part_ge};

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         op_ff    <= op_in;
         mul_a_ff <= mul_a_in;
         mul_b_ff <= mul_b_in;
         num_ff   <= num_in;
      end
      if (cmd.mul) prod_ff <= mul_a_ff * mul_b_ff;
      if (cmd.div_start) begin
         den_ff <= prod_ff;
         rem_ff <= '0;
         quo_ff <= num_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // level update
   logic [NUM_W:0]     sum;
   logic [LEVEL_W-1:0] sat_add, sat_sub;
   logic               clear_t;

   assign sum     = {1'b0, NUM_W'(cur_level_ff)} + {1'b0, quo_ff};
   assign sat_add = (sum > (NUM_W + 1)'(LEVEL_ONE)) ? LEVEL_ONE : LEVEL_W'(sum);
   assign sat_sub = (quo_ff >= NUM_W'(cur_level_ff)) ? '0
                                                     : cur_level_ff - LEVEL_W'(quo_ff);

   always_comb begin
      cur_phase_in      = cur_phase_ff;
      cur_level_in      = cur_level_ff;
      clear_t           = 1'b0;
      rsp_data_in.level = LEVEL_ONE;
      case (op_ff)
         OP_ATK_END: begin
            cur_phase_in = PH_SUSTAIN;
            cur_level_in = LEVEL_ONE;
            clear_t      = 1'b1;
         end
         OP_ATK_STEP: begin
            cur_level_in      = sat_add;
            rsp_data_in.level = sat_add;
         end
         OP_SUS_END: begin
            cur_phase_in = PH_DECAY;
            clear_t      = 1'b1;
         end
         OP_SUS_HOLD: cur_level_in = LEVEL_ONE;
         OP_DEC_HOLD: cur_level_in = cur_level_ff;
         OP_DEC_END: begin
            cur_phase_in      = PH_RELEASE;
            clear_t           = 1'b1;
            rsp_data_in.level = cur_level_ff;
         end
         OP_DEC_UP: begin
            cur_level_in      = sat_add;
            rsp_data_in.level = sat_add;
         end
         OP_DEC_DOWN, OP_REL_STEP: begin
            cur_level_in      = sat_sub;
            rsp_data_in.level = sat_sub;
         end
         OP_REL_END: begin
            cur_phase_in      = PH_IDLE;
            cur_level_in      = '0;
            clear_t           = 1'b1;
            rsp_data_in.level = '0;
         end
         default: begin
            cur_phase_in      = PH_IDLE;
            rsp_data_in.level = '0;
         end
      endcase
      rsp_data_in.phase = cur_phase_in;
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      if (cmd.accept) begin
         if (req_data.req_type) elapsed_in = '0;
         else if (elapsed_ff != COUNT_MAX) elapsed_in = elapsed_ff + 1'b1;
      end else if (cmd.apply && clear_t) begin
         elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_phase_ff <= PH_IDLE;
         elapsed_ff   <= '0;
         cur_level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         if (cmd.accept && req_data.req_type) begin
            cur_phase_ff <= (req_data.new_phase <= 3'(PH_RELEASE))
                            ? phase_type'(req_data.new_phase) : PH_IDLE;
         end else if (cmd.apply) begin
            cur_phase_ff <= cur_phase_in;
            cur_level_ff <= cur_level_in;
         end
         if (cmd.apply) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/adsr_envelope_generator_top.sv */
// Top level of the ADSR envelope generator: controller plus datapath.
// Depends on adsr_pkg, adsr_controller and adsr_datapath.
//
// One request is either a sample tick or a forced phase change. A phase change
// gives no response and leaves the block idle. A tick gives exactly one response,
// the level in unsigned Q1.24 and the phase after the tick. Ticks that only
// hold or end a phase go from evaluation straight to emit; ticks that take an
// attack, decay or release step pass through the multiply, load and divide
// states, where the restoring divider yields one quotient bit per cycle after a
// single multiply for the step denominator. One request is in work at a time;
// a finished response waits in the output register while the next request is
// accepted. The csr_ port is always ready and must only be written while the
// block is idle.
module adsr_envelope_generator_top #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  adsr_pkg::req_payload_type      req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output adsr_pkg::rsp_payload_type      rsp_data,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [adsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [adsr_pkg::CFG_W-1:0]     csr_data
);
   import adsr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   adsr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   adsr_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // level never leaves 0..1.0
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.level <= LEVEL_ONE)
      else $error("response level above 1.0");

   // idle responses carry zero level
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.phase == PH_IDLE) |-> rsp_data.level == '0)
      else $error("idle response with nonzero level");

   // sustain responses carry full level
   a_sustain_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.phase == PH_SUSTAIN) |-> rsp_data.level == LEVEL_ONE)
      else $error("sustain response below full level");

   // a phase change request never produces a response
   a_no_rsp_for_phase: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.req_type && !(rsp_valid && rsp_stall))
      |=> !rsp_valid)
      else $error("response produced by a phase change");

endmodule

/* tb/adsr_checker.sv */
// Checker for the ADSR envelope generator: watches the request, response and register ports,
// predicts every response and compares it field by field. Depends on adsr_pkg.
`timescale 1ns / 100ps

module adsr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  adsr_pkg::req_payload_type      req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  adsr_pkg::rsp_payload_type      rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [adsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [adsr_pkg::CFG_W-1:0]     csr_data,
   output int                             fail_count,
   output int                             pending,
   output int                             checked
);
   import adsr_pkg::*;

   localparam longint unsigned ONE_Q  = longint'(1) << FRAC_BITS;
   localparam longint unsigned CNT_MAX = (longint'(1) << COUNT_BITS_DEFAULT) - 1;

   longint unsigned attack_q, sustain_q, decay_q, release_q;
   longint unsigned tick_cnt, env_q;
   phase_type       env_phase;
   rsp_payload_type level_queue[$];

   function automatic longint unsigned curve_step(longint unsigned t, longint unsigned len);
      longint unsigned den;
      den = (t + len) * (t - 1 + len);
      return (den == 0) ? 0 : ((2 * len) << FRAC_BITS) / den;
   endfunction

   // Advance the envelope model by one request; returns 1 when a response is due.
   function automatic bit envelope_advance(req_payload_type r, output rsp_payload_type o);
      longint unsigned t, v, d, den, out_lvl;
      out_lvl = 0;
      if (r.req_type) begin
         env_phase = (r.new_phase <= PH_RELEASE) ? phase_type'(r.new_phase) : PH_IDLE;
         tick_cnt  = 0;
         return 0;
      end
      if (tick_cnt < CNT_MAX) tick_cnt++;
      t = tick_cnt;
      case (env_phase)
         PH_ATTACK: begin
            if (env_q >= ONE_Q || t >= attack_q) begin
               env_phase = PH_SUSTAIN;
               tick_cnt  = 0;
               env_q     = ONE_Q;
            end else begin
               v     = env_q + curve_step(t, attack_q);
               env_q = (v > ONE_Q) ? ONE_Q : v;
            end
            out_lvl = env_q;
         end
         PH_SUSTAIN: begin
            if (t >= sustain_q) begin
               env_phase = PH_DECAY;
               tick_cnt  = 0;
            end else begin
               env_q = ONE_Q;
            end
            out_lvl = ONE_Q;
         end
         PH_DECAY: begin
            if (t >= decay_q - decay_q / 5) begin
               if (decay_q == 0) begin
                  out_lvl = ONE_Q;
               end else begin
                  env_phase = PH_RELEASE;
                  tick_cnt  = 0;
                  out_lvl   = env_q;
               end
            end else begin
               den = decay_q * decay_q;
               if (t < 2) begin
                  // first decay tick nudges the level up
                  v     = env_q + ONE_Q / den;
                  env_q = (v > ONE_Q) ? ONE_Q : v;
               end else begin
                  d     = ((t - 2) << FRAC_BITS) / den;
                  env_q = (d >= env_q) ? 0 : env_q - d;
               end
               out_lvl = env_q;
            end
         end
         PH_RELEASE: begin
            if (t >= release_q || env_q == 0) begin
               env_phase = PH_IDLE;
               tick_cnt  = 0;
               env_q     = 0;
            end else begin
               d     = curve_step(t, release_q);
               env_q = (d >= env_q) ? 0 : env_q - d;
            end
            out_lvl = env_q;
         end
         default: begin
            env_phase = PH_IDLE;
            out_lvl   = 0;
         end
      endcase
      o.level = out_lvl[LEVEL_W-1:0];
      o.phase = env_phase;
      return 1;
   endfunction

   assign pending = level_queue.size();

   always @(posedge clock) begin
      rsp_payload_type want, got;
      if (reset) begin
         attack_q   <= ATTACK_RESET;
         sustain_q  <= SUSTAIN_RESET;
         decay_q    <= DECAY_RESET;
         release_q  <= RELEASE_RESET;
         env_phase  = PH_IDLE;
         tick_cnt   = 0;
         env_q      = 0;
         level_queue.delete();
         fail_count <= 0;
         checked    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (level_queue.size() == 0) begin
               $display("%0t: unexpected response level=%0d phase=%0d", $time,
                        rsp_data.level, rsp_data.phase);
               fail_count <= fail_count + 1;
            end else begin
               want = level_queue.pop_front();
               checked <= checked + 1;
               if (rsp_data.level !== want.level) begin
                  $display("%0t: level mismatch expected %0d actual %0d", $time,
                           want.level, rsp_data.level);
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.phase !== want.phase) begin
                  $display("%0t: phase mismatch expected %0d actual %0d", $time,
                           want.phase, rsp_data.phase);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            if (envelope_advance(req_data, got)) level_queue.push_back(got);
         if (csr_valid && csr_ready)
            case (csr_index_type'(csr_index))
               CSR_ATTACK:  attack_q  <= csr_data;
               CSR_SUSTAIN: sustain_q <= csr_data;
               CSR_DECAY:   decay_q   <= csr_data;
               CSR_RELEASE: release_q <= csr_data;
               default:     ;
            endcase
      end
   end

endmodule

/* tb/tb_top.sv */
// Top of the ADSR envelope generator testbench: clock, reset, stimulus and verdict.
// Depends on adsr_pkg, adsr_envelope_generator_top and adsr_checker.
`timescale 1ns / 100ps

module tb_top;
   import adsr_pkg::*;

   localparam logic REQ_TICK      = 1'b0;
   localparam logic REQ_SET_PHASE = 1'b1;
   localparam int   SEGMENTS      = 10;
   localparam int   SEG_ITEMS     = 170;
   localparam int   DRAIN_CYCLES  = 80;   // longer than a step tick takes to finish
   localparam int   LONG_HOLD     = 400;

   logic                 clock, reset;
   logic                 req_valid, req_stall;
   req_payload_type      req_data;
   logic                 rsp_valid, rsp_stall;
   rsp_payload_type      rsp_data;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   int                   fail_count, pending, checked;

   // knobs shared with the response-side process
   bit quiet;       // no idling at all
   bit hold_rsp;    // request a long response hold-off
   int sent, cfg_sets;

   adsr_envelope_generator_top dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   adsr_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending, .checked
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run-away guard
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Response side: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until taken; valid stays up unless a gap follows.
   task automatic send_request(logic kind, logic [2:0] ph);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, new_phase: ph};
      do @(posedge clock); while (req_stall);
      sent++;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick(int n);
      repeat (n) send_request(REQ_TICK, 3'($urandom));
   endtask

   task automatic set_phase(logic [2:0] ph);
      send_request(REQ_SET_PHASE, ph);
   endtask

   // Wait until every predicted response is back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Drain, then write all four lengths back to back.
   task automatic load_lengths(logic [CFG_W-1:0] a, s, d, r);
      logic [CFG_W-1:0] vals[4];
      drain();
      vals = '{a, s, d, r};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_sets++;
   endtask

   function automatic logic [CFG_W-1:0] rand_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return CFG_W'($urandom_range(0, 40));
      if (pick < 85) return CFG_W'($urandom_range(0, 4000));
      return CFG_W'($urandom);
   endfunction

   initial begin
      int n;
      int ta, tr;
      bit paused;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      quiet     = 1'b0;
      hold_rsp  = 1'b0;
      sent      = 0;
      cfg_sets  = 0;
      paused    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset lengths; idle ticks, out-of-range phase codes, each phase once.
      tick(1);
      for (int p = int'(PH_RELEASE) + 1; p < 8; p++) begin
         set_phase(3'(p));
         tick(1);
      end
      set_phase(PH_ATTACK);   tick(3);
      set_phase(PH_SUSTAIN);  tick(1);
      set_phase(PH_DECAY);    tick(2);   // first decay tick rises
      set_phase(PH_RELEASE);  tick(2);
      set_phase(PH_IDLE);     tick(1);

      // Zero lengths: attack ends at once, sustain ends at once, decay holds full level.
      load_lengths('0, '0, '0, '0);
      set_phase(PH_ATTACK);   tick(4);
      set_phase(PH_RELEASE);  tick(2);   // zero release goes straight idle

      // Tiny lengths walk the whole envelope down to idle.
      load_lengths(CFG_W'(1), CFG_W'(2), CFG_W'(5), CFG_W'(3));
      set_phase(PH_ATTACK);   tick(16);

      // Largest lengths.
      load_lengths('1, '1, '1, '1);
      set_phase(PH_ATTACK);   tick(2);
      set_phase(PH_DECAY);    tick(3);
      set_phase(PH_RELEASE);  tick(2);

      // Random: note-on/ticks/note-off/ticks sequences with some noise, new lengths per segment.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS - 1) begin
            quiet = 1'b1;
            load_lengths(CFG_W'(2), CFG_W'(3), CFG_W'(6), CFG_W'(4));
         end else if (seg == 4) begin
            load_lengths(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         CFG_W'($urandom));
         end else begin
            load_lengths(rand_len(), rand_len(), rand_len(), rand_len());
         end
         if (seg == 2) hold_rsp = 1'b1;   // block backs up and stalls requests
         n = 0;
         while (n < SEG_ITEMS) begin
            if (seg == 3 && !paused && n > SEG_ITEMS / 2) begin
               // sender pause until everything is back
               paused = 1'b1;
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 85) begin
               ta = $urandom_range(0, 40);
               tr = $urandom_range(0, 20);
               set_phase(PH_ATTACK);
               tick(ta);
               set_phase(PH_RELEASE);
               tick(tr);
               n += 2 + ta + tr;
            end else begin
               send_request(1'($urandom), 3'($urandom));
               n += 1;
            end
         end
      end

      drain();
      $display("Sent %0d requests over %0d length settings; %0d responses checked.",
               sent, cfg_sets, checked);
      $display("Covered every phase, zero/tiny/full-scale lengths and stall back-pressure.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
